### design/efcd_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// efcd_pkg
// Shared types, ring tables and register codes of the event corner detector.
// -----------------------------------------------------------------------------
`default_nettype none

package efcd_pkg;

	localparam int N3     = 16;
	localparam int N4     = 20;
	localparam int NPTS   = N3 + N4;
	localparam int MARGIN = 4;
	localparam int LO3    = 3;
	localparam int HI3    = 6;
	localparam int LO4    = 4;
	localparam int HI4    = 8;

	typedef logic signed [3:0] ofs_t;

	// ring points: radius-3 circle first, radius-4 circle after it
	localparam ofs_t RING_DX [NPTS] = '{
		4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
		4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1,
		4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
		4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1
	};
	localparam ofs_t RING_DY [NPTS] = '{
		4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
		-4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4,
		-4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4
	};

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_EVAL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### design/efcd_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// efcd_ram
// Single-port synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module efcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

### design/efcd_arc.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// efcd_arc
// Arc test for one candidate: marks ring points not older than the candidate
// and checks that they form one contiguous arc of allowed length.
// -----------------------------------------------------------------------------
`default_nettype none

module efcd_arc
	import efcd_pkg::*;
(
	input  wire logic [31:0] pts [N4],
	input  wire logic [31:0] cand,
	input  wire logic        ring4,
	output logic             hit
);

	logic [N4-1:0] mask;
	logic [N4-1:0] rise;
	logic [4:0]    ones;
	logic [4:0]    rises;

	always_comb begin
		for (int j = 0; j < N4; j++) begin
			mask[j] = (ring4 || j < N3) && (pts[j] >= cand);
		end
		for (int j = 0; j < N4; j++) begin
			if (j == 0) begin
				rise[j] = mask[j] & ~(ring4 ? mask[N4-1] : mask[N3-1]);
			end else begin
				rise[j] = mask[j] & ~mask[j-1];
			end
		end
		ones  = 5'($countones(mask));
		rises = 5'($countones(rise));
		if (ring4) begin
			hit = (rises == 5'd1) && (ones >= 5'(LO4)) && (ones <= 5'(HI4));
		end else begin
			hit = (rises == 5'd1) && (ones >= 5'(LO3)) && (ones <= 5'(HI3));
		end
	end

endmodule

`default_nettype wire

### design/event_fast_corner_detector_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// event_fast_corner_detector_top
// Corner detector on four time surfaces held in one single-port memory.
// -----------------------------------------------------------------------------
//  channel   direction  content
//  s_*       in         event: x, y, stamp in tdata; channel, polarity in tuser
//  m_*       out        result: x, y, time, corner flag in tdata; channel,
//                       polarity in tuser
//  p*        in/out     register access: active width, active height
//
// An event near the frame edge goes from its write straight to the result;
// any other event does one write plus 36 ring reads through the single memory
// port, then one arc candidate per cycle over the 36 ring points.
// After reset a clearing pass zeroes the surfaces; no event is taken meanwhile,
// register writes are.
// A held result blocks the next event until it is taken.
// -----------------------------------------------------------------------------
`default_nettype none

module event_fast_corner_detector_top
	import efcd_pkg::*;
#(
	parameter int SENSOR_SIDE = 128,
	parameter int STAMP_BITS  = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // x[6:0], y[13:7], stamp[37:14]
	input  wire logic [1:0]  s_tuser,   // channel[0], polarity[1]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // out_x[6:0], out_y[13:7], time_res[45:14],
	                                    // is_corner[46]
	output logic      [1:0]  m_tuser,   // out_channel[0], out_polarity[1]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int CW    = $clog2(SENSOR_SIDE);
	localparam int AW    = 2 + 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = (STAMP_BITS < 24) ? STAMP_BITS : 24;
	localparam logic [23:0] STAMP_MASK = 24'((64'd1 << SW) - 64'd1);
	localparam logic [10:0] SIDE11 = 11'(SENSOR_SIDE);

	state_t state_q, state_d;

	logic [7:0]    aw_q, ah_q;
	logic [23:0]   last_q;
	logic [7:0]    wrap_q;
	logic [AW-1:0] clr_q;
	logic [5:0]    rd_idx_q;
	logic          cap_vld_s1;
	logic [5:0]    cap_idx_s1;
	logic [5:0]    cand_q;
	logic          pass3_q, pass4_q;
	logic [6:0]    x_q, y_q;
	logic          ch_q, pol_q;
	logic [31:0]   tres_q;
	logic          inner_q, store_q;
	logic [31:0]   pts_q [NPTS];

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	logic          s_acc;
	logic [6:0]    in_x, in_y;
	logic [23:0]   in_stamp;
	logic [7:0]    wrap_d;
	logic [31:0]   tres_d;
	logic [10:0]   uw, uh, x11, y11;
	logic          inner_d, store_d;
	logic [CW-1:0] xc, yc, rx, ry;
	logic [31:0]   arc_pts [N4];
	logic          ring4, hit;

	assign s_acc    = s_tvalid && s_tready;
	assign in_x     = s_tdata[6:0];
	assign in_y     = s_tdata[13:7];
	assign in_stamp = s_tdata[37:14] & STAMP_MASK;

	always_comb begin
		wrap_d  = (in_stamp < last_q) ? wrap_q + 8'd1 : wrap_q;
		tres_d  = 32'((40'(wrap_d) << STAMP_BITS) + 40'(in_stamp));
		x11     = 11'(in_x);
		y11     = 11'(in_y);
		uw      = (11'(aw_q) < SIDE11) ? 11'(aw_q) : SIDE11;
		uh      = (11'(ah_q) < SIDE11) ? 11'(ah_q) : SIDE11;
		store_d = (x11 < SIDE11) && (y11 < SIDE11);
		inner_d = (x11 >= 11'(MARGIN)) && (y11 >= 11'(MARGIN))
		       && (x11 + 11'(MARGIN) < uw) && (y11 + 11'(MARGIN) < uh);
	end

	// register port
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {24'd0, aw_q};
			REG_HEIGHT: prdata = {24'd0, ah_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= 8'd128;
			ah_q <= 8'd128;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_WIDTH:  aw_q <= pwdata[7:0];
				REG_HEIGHT: ah_q <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_d = ST_WRITE;
			ST_WRITE: state_d = inner_q ? ST_READ : ST_DONE;
			ST_READ:  if (rd_idx_q == 6'(NPTS - 1)) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_EVAL;
			ST_EVAL:  if (cand_q == 6'(NPTS - 1)) state_d = ST_DONE;
			ST_DONE:  if (m_tready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs and memory port
	always_comb begin
		xc        = CW'(x_q);
		yc        = CW'(y_q);
		rx        = xc + CW'(RING_DX[rd_idx_q]);
		ry        = yc + CW'(RING_DY[rd_idx_q]);
		s_tready  = (state_q == ST_IDLE);
		m_tvalid  = (state_q == ST_DONE);
		ram_we    = 1'b0;
		ram_wdata = tres_q;
		ram_addr  = {ch_q, pol_q, ry, rx};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = 32'd0;
				ram_addr  = clr_q;
			end
			ST_WRITE: begin
				ram_we   = store_q;
				ram_addr = {ch_q, pol_q, yc, xc};
			end
			default: ;
		endcase
	end

	assign m_tdata = {1'b0, inner_q & pass3_q & pass4_q, tres_q, y_q, x_q};
	assign m_tuser = {pol_q, ch_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			last_q     <= '0;
			wrap_q     <= '0;
			rd_idx_q   <= '0;
			cand_q     <= '0;
			cap_vld_s1 <= 1'b0;
			pass3_q    <= 1'b0;
			pass4_q    <= 1'b0;
			inner_q    <= 1'b0;
			store_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cap_vld_s1 <= (state_q == ST_READ);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (s_acc) begin
				last_q   <= in_stamp;
				wrap_q   <= wrap_d;
				inner_q  <= inner_d;
				store_q  <= store_d;
				pass3_q  <= 1'b0;
				pass4_q  <= 1'b0;
				rd_idx_q <= '0;
				cand_q   <= '0;
			end
			if (state_q == ST_READ) begin
				rd_idx_q <= (rd_idx_q == 6'(NPTS - 1)) ? 6'd0 : rd_idx_q + 6'd1;
			end
			if (state_q == ST_EVAL) begin
				cand_q <= (cand_q == 6'(NPTS - 1)) ? 6'd0 : cand_q + 6'd1;
				if (ring4) begin
					pass4_q <= pass4_q | hit;
				end else begin
					pass3_q <= pass3_q | hit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cap_idx_s1 <= rd_idx_q;
		if (s_acc) begin
			x_q    <= in_x;
			y_q    <= in_y;
			ch_q   <= s_tuser[0];
			pol_q  <= s_tuser[1];
			tres_q <= tres_d;
		end
		if (cap_vld_s1) begin
			pts_q[cap_idx_s1] <= ram_rdata;
		end
	end

	efcd_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_surf (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign ring4 = (cand_q >= 6'(N3));
	always_comb begin
		for (int j = 0; j < N4; j++) begin
			if (ring4) begin
				arc_pts[j] = pts_q[N3 + j];
			end else if (j < N3) begin
				arc_pts[j] = pts_q[j];
			end else begin
				arc_pts[j] = 32'd0;
			end
		end
	end

	efcd_arc u_arc (
		.pts   (arc_pts),
		.cand  (pts_q[cand_q]),
		.ring4 (ring4),
		.hit   (hit)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken while a result is pending");

	a_corner_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[46]) |-> inner_q)
		else $error("corner flagged near the frame edge");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
		else $error("surface write outside clear or store phase");

	a_accept_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (state_q == ST_WRITE && !m_tvalid))
		else $error("accepted event did not enter the store phase");

endmodule

`default_nettype wire

### dv/event_fast_corner_detector_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// event_fast_corner_detector_top_tb
// Self-checking bench of the event corner detector. Events go in on the slave
// stream and results are matched, field by field, against a behavioral model
// of the timestamp unwrapping, the four time surfaces and both ring arc tests.
// A short directed table comes first. After it comes random traffic, most of
// it built as ring arcs around a center so that corners do come up. This runs
// over several width and height settings and several sender and receiver
// stall patterns.
// -----------------------------------------------------------------------------
`default_nettype none

module event_fast_corner_detector_top_tb;
	import efcd_pkg::*;

	localparam int SIDE        = 128;
	localparam int DOG_LIMIT   = 300000;
	localparam int DRAIN_WAIT  = 120;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [6:0]  x;
		logic [6:0]  y;
		logic        ch;
		logic        pol;
		logic [31:0] tres;
		logic        corner;
	} result_t;

	typedef struct {
		logic [6:0]  x;
		logic [6:0]  y;
		logic        ch;
		logic        pol;
		logic [23:0] stamp;
		bit          typed;
		logic [31:0] tres;
		logic        corner;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // x[6:0], y[13:7], stamp[37:14], zero fill
	logic [1:0]  s_tuser;   // channel[0], polarity[1]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // out_x[6:0], out_y[13:7], time_res[45:14], is_corner[46]
	logic [1:0]  m_tuser;   // out_channel[0], out_polarity[1]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [31:0] surface [4*SIDE*SIDE];
	logic [23:0] prev_stamp;
	logic [7:0]  wraps;
	logic [7:0]  act_w;
	logic [7:0]  act_h;

	result_t     pending [$];
	int          mismatches;
	int          idle_cycles;
	int          gap_pct;
	int          stall_pct;
	logic [23:0] stamp_now;

	bit          row_typed;
	logic [31:0] row_tres;
	logic        row_corner;

	event_fast_corner_detector_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit arc_found(input logic [31:0] pts [NPTS], input int base,
			input int n, input int lo, input int hi);
		logic [31:0] mn;
		bit          ok;
		for (int i = 0; i < n; i++) begin
			for (int len = lo; len <= hi; len++) begin
				mn = pts[base + i];
				for (int j = 1; j < len; j++)
					if (pts[base + (i + j) % n] < mn) mn = pts[base + (i + j) % n];
				ok = 1'b1;
				for (int j = len; j < n; j++)
					if (pts[base + (i + j) % n] >= mn) ok = 1'b0;
				if (ok) return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic int surf_addr(input int sel, input int x, input int y);
		return (sel * SIDE + y) * SIDE + x;
	endfunction

	task automatic detect_corner(input logic [6:0] x, input logic [6:0] y, input logic ch,
			input logic pol, input logic [23:0] stamp, output result_t r);
		logic [31:0] pts [NPTS];
		int          sel;
		int          uw;
		int          uh;
		sel = int'({ch, pol});
		if (stamp < prev_stamp) wraps = wraps + 8'd1;
		prev_stamp = stamp;
		r.x      = x;
		r.y      = y;
		r.ch     = ch;
		r.pol    = pol;
		r.tres   = {wraps, stamp};
		r.corner = 1'b0;
		surface[surf_addr(sel, x, y)] = r.tres;
		uw = (act_w < SIDE) ? act_w : SIDE;
		uh = (act_h < SIDE) ? act_h : SIDE;
		if (x >= MARGIN && y >= MARGIN && x + MARGIN < uw && y + MARGIN < uh) begin
			for (int i = 0; i < NPTS; i++)
				pts[i] = surface[surf_addr(sel, int'(x) + int'(RING_DX[i]),
					int'(y) + int'(RING_DY[i]))];
			r.corner = arc_found(pts, 0, N3, LO3, HI3) && arc_found(pts, N3, N4, LO4, HI4);
		end
	endtask

	always @(posedge clk) begin
		result_t r;
		result_t got;
		if (arst_n && s_tvalid && s_tready) begin
			detect_corner(s_tdata[6:0], s_tdata[13:7], s_tuser[0], s_tuser[1],
				s_tdata[37:14], r);
			if (row_typed) begin
				r.tres   = row_tres;
				r.corner = row_corner;
			end
			pending.push_back(r);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[6:0], m_tdata[13:7], m_tuser[0], m_tuser[1], m_tdata[45:14],
				m_tdata[46]};
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction: %p", got);
			end else begin
				r = pending.pop_front();
				if (got !== r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, actual %p", r, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= DOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	task automatic reg_write(input logic idx, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_WIDTH) act_w = value;
		else act_h = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_area(input logic [7:0] w, input logic [7:0] h);
		while (pending.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
	endtask

	task automatic send_event(input logic [6:0] x, input logic [6:0] y, input logic ch,
			input logic pol, input logic [23:0] stamp);
		int gap;
		if ($urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, stamp, y, x};
		s_tuser  <= {pol, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [23:0] advance_stamp();
		if ($urandom_range(99) < 3) stamp_now = 24'($urandom);
		else stamp_now = stamp_now + 24'($urandom_range(1, 300));
		return stamp_now;
	endfunction

	task automatic arc_burst(output int sent);
		int   uw;
		int   uh;
		int   cx;
		int   cy;
		int   s3;
		int   s4;
		int   l3;
		int   l4;
		int   k;
		logic ch;
		logic pol;
		uw  = (act_w < SIDE) ? act_w : SIDE;
		uh  = (act_h < SIDE) ? act_h : SIDE;
		cx  = (uw >= 9) ? $urandom_range(MARGIN, uw - MARGIN - 1) : $urandom_range(0, 127);
		cy  = (uh >= 9) ? $urandom_range(MARGIN, uh - MARGIN - 1) : $urandom_range(0, 127);
		if (cx > 123) cx = 123;
		if (cy > 123) cy = 123;
		if (cx < 4) cx = 4;
		if (cy < 4) cy = 4;
		ch  = 1'($urandom_range(1));
		pol = 1'($urandom_range(1));
		s3  = $urandom_range(15);
		s4  = $urandom_range(19);
		l3  = ($urandom_range(99) < 80) ? $urandom_range(LO3, HI3) : $urandom_range(1, 9);
		l4  = ($urandom_range(99) < 80) ? $urandom_range(LO4, HI4) : $urandom_range(1, 11);
		sent = 0;
		for (int j = 0; j < l3; j++) begin
			k = (s3 + j) % N3;
			send_event(7'(cx + RING_DX[k]), 7'(cy + RING_DY[k]), ch, pol, advance_stamp());
			sent++;
		end
		for (int j = 0; j < l4; j++) begin
			k = N3 + (s4 + j) % N4;
			send_event(7'(cx + RING_DX[k]), 7'(cy + RING_DY[k]), ch, pol, advance_stamp());
			sent++;
		end
		send_event(7'(cx), 7'(cy), ch, pol, advance_stamp());
		sent++;
	endtask

	row_t rows [] = '{
		'{7'd0,   7'd0,   1'b0, 1'b0, 24'h000000, 1'b1, 32'h00000000, 1'b0},
		'{7'd127, 7'd127, 1'b1, 1'b1, 24'hFFFFFF, 1'b1, 32'h00FFFFFF, 1'b0},
		'{7'd0,   7'd127, 1'b0, 1'b1, 24'h000000, 1'b1, 32'h01000000, 1'b0},
		'{7'd127, 7'd0,   1'b1, 1'b0, 24'h000010, 1'b1, 32'h01000010, 1'b0},
		'{7'd64,  7'd64,  1'b1, 1'b0, 24'h000020, 1'b1, 32'h01000020, 1'b0},
		'{7'd3,   7'd64,  1'b0, 1'b0, 24'h000030, 1'b1, 32'h01000030, 1'b0},
		'{7'd124, 7'd64,  1'b0, 1'b0, 24'h000040, 1'b1, 32'h01000040, 1'b0},
		'{7'd64,  7'd3,   1'b0, 1'b1, 24'h000050, 1'b1, 32'h01000050, 1'b0},
		'{7'd64,  7'd124, 1'b1, 1'b1, 24'h000060, 1'b1, 32'h01000060, 1'b0},
		'{7'd4,   7'd4,   1'b0, 1'b0, 24'h000070, 1'b0, 32'h0, 1'b0},
		'{7'd123, 7'd123, 1'b0, 1'b0, 24'h000080, 1'b0, 32'h0, 1'b0},
		'{7'd20,  7'd23,  1'b0, 1'b0, 24'h000100, 1'b0, 32'h0, 1'b0},
		'{7'd21,  7'd23,  1'b0, 1'b0, 24'h000101, 1'b0, 32'h0, 1'b0},
		'{7'd22,  7'd22,  1'b0, 1'b0, 24'h000102, 1'b0, 32'h0, 1'b0},
		'{7'd20,  7'd24,  1'b0, 1'b0, 24'h000103, 1'b0, 32'h0, 1'b0},
		'{7'd21,  7'd24,  1'b0, 1'b0, 24'h000104, 1'b0, 32'h0, 1'b0},
		'{7'd22,  7'd23,  1'b0, 1'b0, 24'h000105, 1'b0, 32'h0, 1'b0},
		'{7'd23,  7'd22,  1'b0, 1'b0, 24'h000106, 1'b0, 32'h0, 1'b0},
		'{7'd20,  7'd20,  1'b0, 1'b0, 24'h000107, 1'b0, 32'h0, 1'b0},
		'{7'd5,   7'd5,   1'b1, 1'b0, 24'hABCDEF, 1'b0, 32'h0, 1'b0},
		'{7'd122, 7'd5,   1'b0, 1'b1, 24'h543210, 1'b0, 32'h0, 1'b0}
	};

	logic [7:0] area_w [8] = '{8'd128, 8'd9,  8'd255, 8'd0,   8'd128, 8'd40, 8'd64, 8'd100};
	logic [7:0] area_h [8] = '{8'd128, 8'd9,  8'd255, 8'd128, 8'd20,  8'd9,  8'd96, 8'd128};
	int         gap_of   [4] = '{0, 46, 0, 10};
	int         stall_of [4] = '{0, 0, 46, 10};

	initial begin
		int sent;
		int burst;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		m_tready    = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		mismatches  = 0;
		idle_cycles = 0;
		gap_pct     = 0;
		stall_pct   = 0;
		stamp_now   = '0;
		row_typed   = 1'b0;
		row_tres    = '0;
		row_corner  = 1'b0;
		prev_stamp  = '0;
		wraps       = '0;
		act_w       = 8'd128;
		act_h       = 8'd128;
		foreach (surface[i]) surface[i] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			row_typed  = rows[i].typed;
			row_tres   = rows[i].tres;
			row_corner = rows[i].corner;
			send_event(rows[i].x, rows[i].y, rows[i].ch, rows[i].pol, rows[i].stamp);
		end
		row_typed = 1'b0;
		stamp_now = 24'h000200;

		for (int k = 0; k < 8; k++) begin
			gap_pct   = gap_of[k / 2];
			stall_pct = stall_of[k / 2];
			s_tvalid <= 1'b0;
			set_area(area_w[k], area_h[k]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 70) begin
					arc_burst(burst);
					sent += burst;
				end else begin
					send_event(7'($urandom_range(127)), 7'($urandom_range(127)),
						1'($urandom_range(1)), 1'($urandom_range(1)), advance_stamp());
					sent++;
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
design/efcd_pkg.sv
design/efcd_ram.sv
design/efcd_arc.sv
design/event_fast_corner_detector_top.sv
dv/event_fast_corner_detector_top_tb.sv
